// File: rtl/ars_pkg.sv
// Shared types and constants of the ack/retry session table.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ars_pkg;

   // Field widths fixed by the interface.
   localparam int TYPE_W     = 2;
   localparam int CADDR_W    = 4;
   localparam int TIME_W     = 32;
   localparam int RETRY_W    = 8;
   localparam int INTERVAL_W = 16;
   localparam int ACTION_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Request types.
   localparam logic [TYPE_W-1:0] REQ_RECV  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_SEND  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SWEEP = 2'd2;

   // Result actions.
   localparam logic [ACTION_W-1:0] ACT_ACK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEND   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RETRY  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 2'd2;

   // Configuration reset values.
   localparam logic [RETRY_W-1:0]    RST_RETRY_LIMIT = 8'd3;
   localparam logic [INTERVAL_W-1:0] RST_RETRY_INTV  = 16'd1000;
   localparam logic [TIME_W-1:0]     RST_TIMEOUT     = 32'd10000;

   // Write enables from the controller to the session memories.
   typedef struct packed {
      logic stamp_we;
      logic retry_we;
   } mem_ctl_type;

endpackage

`default_nettype wire

// File: rtl/ars_csr.sv
// Configuration registers of the session table: retry limit, retry interval
// and session timeout. Depends on ars_pkg.
`default_nettype none

module ars_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ars_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ars_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [ars_pkg::RETRY_W-1:0]          retry_limit,
   output logic [ars_pkg::INTERVAL_W-1:0]       retry_interval_ms,
   output logic [ars_pkg::TIME_W-1:0]           session_timeout_ms
);

   logic [ars_pkg::RETRY_W-1:0]    retry_limit_ff, retry_limit_in;
   logic [ars_pkg::INTERVAL_W-1:0] retry_intv_ff, retry_intv_in;
   logic [ars_pkg::TIME_W-1:0]     timeout_ff, timeout_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode a write transfer; an unknown index changes nothing.
   always_comb begin
      retry_limit_in = retry_limit_ff;
      retry_intv_in  = retry_intv_ff;
      timeout_in     = timeout_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ars_pkg::CSR_RETRY_LIMIT: retry_limit_in = csr_wdata[ars_pkg::RETRY_W-1:0];
            ars_pkg::CSR_RETRY_INTV:  retry_intv_in  = csr_wdata[ars_pkg::INTERVAL_W-1:0];
            ars_pkg::CSR_TIMEOUT:     timeout_in     = csr_wdata[ars_pkg::TIME_W-1:0];
            default:                  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= ars_pkg::RST_RETRY_LIMIT;
         retry_intv_ff  <= ars_pkg::RST_RETRY_INTV;
         timeout_ff     <= ars_pkg::RST_TIMEOUT;
      end else begin
         retry_limit_ff <= retry_limit_in;
         retry_intv_ff  <= retry_intv_in;
         timeout_ff     <= timeout_in;
      end
   end

   assign retry_limit        = retry_limit_ff;
   assign retry_interval_ms  = retry_intv_ff;
   assign session_timeout_ms = timeout_ff;

endmodule

`default_nettype wire

// File: rtl/ars_mem.sv
// Session memories: last-activity stamp and retry count per client address.
// One write port and one registered read port each. Depends on ars_pkg.
`default_nettype none

module ars_mem #(
   parameter int ADDR_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire ars_pkg::mem_ctl_type             mem_ctl,
   input  wire logic [$clog2(ADDR_COUNT)-1:0]    wr_addr,
   input  wire logic [ars_pkg::TIME_W-1:0]       wr_stamp,
   input  wire logic [ars_pkg::RETRY_W-1:0]      wr_retries,
   input  wire logic [$clog2(ADDR_COUNT)-1:0]    rd_addr,
   output logic [ars_pkg::TIME_W-1:0]            rd_stamp,
   output logic [ars_pkg::RETRY_W-1:0]           rd_retries
);

   logic [ars_pkg::TIME_W-1:0]  stamp_mem [ADDR_COUNT];
   logic [ars_pkg::RETRY_W-1:0] retry_mem [ADDR_COUNT];
   logic [ars_pkg::TIME_W-1:0]  rd_stamp_ff;
   logic [ars_pkg::RETRY_W-1:0] rd_retries_ff;

   // Write ports.
   always_ff @(posedge clock) begin
      if (mem_ctl.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      if (mem_ctl.retry_we) begin
         retry_mem[wr_addr] <= wr_retries;
      end
   end

   // Read ports with registered data.
   always_ff @(posedge clock) begin
      rd_stamp_ff   <= stamp_mem[rd_addr];
      rd_retries_ff <= retry_mem[rd_addr];
   end

   assign rd_stamp   = rd_stamp_ff;
   assign rd_retries = rd_retries_ff;

endmodule

`default_nettype wire

// File: rtl/ars_ctrl.sv
// Request sequencer of the session table: session flags, the sweep walk over
// the memories, a one-deep hold for the last-result mark and the result
// register. Depends on ars_pkg.
`default_nettype none

module ars_ctrl #(
   parameter int ADDR_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ars_pkg::TYPE_W-1:0]       req_type,
   input  wire logic [ars_pkg::CADDR_W-1:0]      req_client_addr,
   input  wire logic [ars_pkg::TIME_W-1:0]       req_now_ms,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ars_pkg::ACTION_W-1:0]          rsp_action,
   output logic [ars_pkg::CADDR_W-1:0]           rsp_target_addr,
   output logic                                  rsp_last,
   // Configuration.
   input  wire logic [ars_pkg::RETRY_W-1:0]      retry_limit,
   input  wire logic [ars_pkg::INTERVAL_W-1:0]   retry_interval_ms,
   input  wire logic [ars_pkg::TIME_W-1:0]       session_timeout_ms,
   // Memory access.
   output ars_pkg::mem_ctl_type                  mem_ctl,
   output logic [$clog2(ADDR_COUNT)-1:0]         mem_wr_addr,
   output logic [ars_pkg::TIME_W-1:0]            mem_wr_stamp,
   output logic [ars_pkg::RETRY_W-1:0]           mem_wr_retries,
   output logic [$clog2(ADDR_COUNT)-1:0]         mem_rd_addr,
   input  wire logic [ars_pkg::TIME_W-1:0]       mem_rd_stamp,
   input  wire logic [ars_pkg::RETRY_W-1:0]      mem_rd_retries
);

   localparam int AW = $clog2(ADDR_COUNT);
   localparam logic [AW-1:0] LAST_IDX = AW'(ADDR_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ONE   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [ars_pkg::TYPE_W-1:0]      type_ff, type_in;
   logic [ars_pkg::CADDR_W-1:0]     addr_ff, addr_in;
   logic [ars_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [AW-1:0]                   idx_ff, idx_in;
   logic [ADDR_COUNT-1:0]           present_ff, present_in;
   logic [ADDR_COUNT-1:0]           waiting_ff, waiting_in;
   logic                            hold_valid_ff, hold_valid_in;
   logic [ars_pkg::ACTION_W-1:0]    hold_action_ff, hold_action_in;
   logic [ars_pkg::CADDR_W-1:0]     hold_addr_ff, hold_addr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ars_pkg::ACTION_W-1:0]    rsp_action_ff, rsp_action_in;
   logic [ars_pkg::CADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            out_free;
   logic                            req_in_range;
   logic [AW-1:0]                   req_idx;
   logic [ars_pkg::TIME_W-1:0]      idle_ms;
   logic                            over_retry;
   logic                            over_time;
   logic                            exhausted;
   logic                            res_retry;
   logic                            res_drop;
   logic                            res_valid;
   logic                            stall;

   // The result register can load when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Client address check for receive and send requests.
   assign req_in_range = (32'(req_client_addr) < 32'(ADDR_COUNT));
   assign req_idx      = AW'(addr_ff);

   // Sweep decision for the entry whose memory data is on the read port.
   assign idle_ms    = now_ff - mem_rd_stamp;
   assign over_retry = idle_ms > 32'(retry_interval_ms);
   assign over_time  = idle_ms > session_timeout_ms;
   assign exhausted  = mem_rd_retries >= retry_limit;
   assign res_retry  = present_ff[idx_ff] && waiting_ff[idx_ff] && over_retry && !exhausted;
   assign res_drop   = present_ff[idx_ff] && !res_retry &&
                       ((waiting_ff[idx_ff] && exhausted) || over_time);
   assign res_valid  = res_retry || res_drop;
   assign stall      = res_valid && hold_valid_ff && !out_free;

   // Next-state logic.
   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      addr_in        = addr_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      present_in     = present_ff;
      waiting_in     = waiting_ff;
      hold_valid_in  = hold_valid_ff;
      hold_action_in = hold_action_ff;
      hold_addr_in   = hold_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_last_in    = rsp_last_ff;
      mem_ctl        = '0;
      mem_wr_addr    = idx_ff;
      mem_wr_stamp   = now_ff;
      mem_wr_retries = '0;
      mem_rd_addr    = idx_ff;
      req_ready      = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in = req_type;
               addr_in = req_client_addr;
               now_in  = req_now_ms;
               idx_in  = '0;
               if ((req_type == ars_pkg::REQ_RECV || req_type == ars_pkg::REQ_SEND) &&
                   req_in_range) begin
                  state_in = ST_ONE;
               end else if (req_type == ars_pkg::REQ_SWEEP) begin
                  state_in = ST_READ;
               end
            end
         end

         // Receive or send: stamp the session and answer once.
         ST_ONE: begin
            if (out_free) begin
               mem_wr_addr      = req_idx;
               mem_ctl.stamp_we = 1'b1;
               present_in[req_idx] = 1'b1;
               if (type_ff == ars_pkg::REQ_SEND) begin
                  mem_ctl.retry_we    = 1'b1;
                  waiting_in[req_idx] = 1'b1;
                  rsp_action_in       = ars_pkg::ACT_SEND;
               end else begin
                  mem_ctl.retry_we    = !present_ff[req_idx];
                  waiting_in[req_idx] = 1'b0;
                  rsp_action_in       = ars_pkg::ACT_ACK;
               end
               rsp_valid_in = 1'b1;
               rsp_addr_in  = addr_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // First read of the sweep is in flight.
         ST_READ: begin
            state_in = ST_EVAL;
         end

         // One entry per cycle while not stalled; a found result waits in the hold register
         // until the next one or the end of the sweep decides its last mark.
         ST_EVAL: begin
            if (!stall) begin
               if (res_retry) begin
                  mem_ctl.stamp_we = 1'b1;
                  mem_ctl.retry_we = 1'b1;
                  mem_wr_retries   = mem_rd_retries + 1'b1;
               end
               if (res_drop) begin
                  present_in[idx_ff] = 1'b0;
                  waiting_in[idx_ff] = 1'b0;
               end
               if (res_valid) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = hold_action_ff;
                     rsp_addr_in   = hold_addr_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in  = 1'b1;
                  hold_action_in = res_retry ? ars_pkg::ACT_RETRY : ars_pkg::ACT_REMOVE;
                  hold_addr_in   = ars_pkg::CADDR_W'(idx_ff);
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  mem_rd_addr = idx_ff + 1'b1;
               end
            end
         end

         // Deliver the held result as the final one of the sweep.
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = hold_action_ff;
               rsp_addr_in   = hold_addr_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         present_ff    <= '0;
         waiting_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         present_ff    <= present_in;
         waiting_ff    <= waiting_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      addr_ff        <= addr_in;
      now_ff         <= now_in;
      hold_action_ff <= hold_action_in;
      hold_addr_ff   <= hold_addr_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_target_addr = rsp_addr_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/ack_retry_session_table.sv
// Stop-and-wait session table: per-client ack, transmit, retransmit and removal.
// Receive/send: the ST_ONE state follows the request transfer and loads the result register
// once it is free. Sweep: ST_READ issues the first read, then ST_EVAL walks the memories
// one entry per cycle unless the output stalls; a found result appears one found entry late.
// One item is in work at a time. Reset clears the session flags and restores
// the configuration defaults at once; stamps and retry counts are written on use.
`default_nettype none

module ack_retry_session_table #(
   parameter int ADDR_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ars_pkg::TYPE_W-1:0]       req_type,
   input  wire logic [ars_pkg::CADDR_W-1:0]      req_client_addr,
   input  wire logic [ars_pkg::TIME_W-1:0]       req_now_ms,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ars_pkg::ACTION_W-1:0]          rsp_action,
   output logic [ars_pkg::CADDR_W-1:0]           rsp_target_addr,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ars_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ars_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(ADDR_COUNT);

   logic [ars_pkg::RETRY_W-1:0]    retry_limit;
   logic [ars_pkg::INTERVAL_W-1:0] retry_interval_ms;
   logic [ars_pkg::TIME_W-1:0]     session_timeout_ms;
   ars_pkg::mem_ctl_type           mem_ctl;
   logic [AW-1:0]                  mem_wr_addr;
   logic [ars_pkg::TIME_W-1:0]     mem_wr_stamp;
   logic [ars_pkg::RETRY_W-1:0]    mem_wr_retries;
   logic [AW-1:0]                  mem_rd_addr;
   logic [ars_pkg::TIME_W-1:0]     mem_rd_stamp;
   logic [ars_pkg::RETRY_W-1:0]    mem_rd_retries;

   // Configuration registers.
   ars_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .retry_limit        (retry_limit),
      .retry_interval_ms  (retry_interval_ms),
      .session_timeout_ms (session_timeout_ms)
   );

   // Stamp and retry-count memories.
   ars_mem #(
      .ADDR_COUNT (ADDR_COUNT)
   ) u_mem (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .wr_addr    (mem_wr_addr),
      .wr_stamp   (mem_wr_stamp),
      .wr_retries (mem_wr_retries),
      .rd_addr    (mem_rd_addr),
      .rd_stamp   (mem_rd_stamp),
      .rd_retries (mem_rd_retries)
   );

   // Request sequencer and result register.
   ars_ctrl #(
      .ADDR_COUNT (ADDR_COUNT)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_client_addr    (req_client_addr),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_target_addr    (rsp_target_addr),
      .rsp_last           (rsp_last),
      .retry_limit        (retry_limit),
      .retry_interval_ms  (retry_interval_ms),
      .session_timeout_ms (session_timeout_ms),
      .mem_ctl            (mem_ctl),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_stamp       (mem_wr_stamp),
      .mem_wr_retries     (mem_wr_retries),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_stamp       (mem_rd_stamp),
      .mem_rd_retries     (mem_rd_retries)
   );

endmodule

`default_nettype wire

// File: verif/ack_retry_session_table_tb.sv
// Self-checking testbench for the ack/retry session table.
// Depends on ars_pkg and ack_retry_session_table; predicts every result item in place.
`default_nettype none

module ack_retry_session_table_tb;

   localparam int ADDR_COUNT   = 16;
   localparam int DRAIN_CYCLES = 2 * ADDR_COUNT + 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_PRINTS   = 30;

   // Codes the package does not name.
   localparam logic [ars_pkg::TYPE_W-1:0]    REQ_UNUSED = 2'd3;
   localparam logic [ars_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ars_pkg::ACTION_W-1:0] action;
      logic [ars_pkg::CADDR_W-1:0]  target;
      logic                         last_flag;
   } action_item_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [ars_pkg::TYPE_W-1:0]     req_type;
   logic [ars_pkg::CADDR_W-1:0]    req_client_addr;
   logic [ars_pkg::TIME_W-1:0]     req_now_ms;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [ars_pkg::ACTION_W-1:0]   rsp_action;
   logic [ars_pkg::CADDR_W-1:0]    rsp_target_addr;
   logic                           rsp_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ars_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ars_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Predicted session table and configuration.
   logic                           sess_present [ADDR_COUNT];
   logic                           sess_waiting [ADDR_COUNT];
   logic [ars_pkg::RETRY_W-1:0]    sess_retries [ADDR_COUNT];
   logic [ars_pkg::TIME_W-1:0]     sess_stamp   [ADDR_COUNT];
   logic [ars_pkg::RETRY_W-1:0]    cfg_retry_limit;
   logic [ars_pkg::INTERVAL_W-1:0] cfg_retry_intv;
   logic [ars_pkg::TIME_W-1:0]     cfg_timeout;

   action_item_type                expected_actions[$];
   logic [ars_pkg::TIME_W-1:0]     now_track;
   int                             error_count;
   int                             rsp_hold_cycles;
   bit                             req_idle_on;
   bit                             rsp_idle_on;

   ack_retry_session_table #(
      .ADDR_COUNT(ADDR_COUNT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_client_addr(req_client_addr),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_target_addr(rsp_target_addr),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTS) begin
         $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      end
      error_count++;
   endtask

   // Table state after reset: no sessions, default configuration.
   task automatic reset_table_model();
      for (int a = 0; a < ADDR_COUNT; a++) begin
         sess_present[a] = 1'b0;
         sess_waiting[a] = 1'b0;
         sess_retries[a] = '0;
         sess_stamp[a]   = '0;
      end
      cfg_retry_limit = ars_pkg::RST_RETRY_LIMIT;
      cfg_retry_intv  = ars_pkg::RST_RETRY_INTV;
      cfg_timeout     = ars_pkg::RST_TIMEOUT;
   endtask

   function automatic void apply_csr_write(input logic [ars_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [ars_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         ars_pkg::CSR_RETRY_LIMIT: cfg_retry_limit = data[ars_pkg::RETRY_W-1:0];
         ars_pkg::CSR_RETRY_INTV:  cfg_retry_intv  = data[ars_pkg::INTERVAL_W-1:0];
         ars_pkg::CSR_TIMEOUT:     cfg_timeout     = data[ars_pkg::TIME_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic action_item_type make_action(
      input logic [ars_pkg::ACTION_W-1:0] act,
      input logic [ars_pkg::CADDR_W-1:0]  addr);
      action_item_type item;
      item.action    = act;
      item.target    = addr;
      item.last_flag = 1'b0;
      return item;
   endfunction

   function automatic void drop_session(input int a);
      sess_present[a] = 1'b0;
      sess_waiting[a] = 1'b0;
      sess_retries[a] = '0;
   endfunction

   // Work out the actions one accepted request causes and queue them.
   function automatic void predict_table_actions(input logic [ars_pkg::TYPE_W-1:0] kind,
                                                 input logic [ars_pkg::CADDR_W-1:0] addr,
                                                 input logic [ars_pkg::TIME_W-1:0] now);
      action_item_type found[$];
      logic [ars_pkg::TIME_W-1:0] idle;
      if (kind == ars_pkg::REQ_RECV || kind == ars_pkg::REQ_SEND) begin
         if (!sess_present[addr]) begin
            sess_present[addr] = 1'b1;
            sess_retries[addr] = '0;
         end
         sess_stamp[addr] = now;
         if (kind == ars_pkg::REQ_RECV) begin
            sess_waiting[addr] = 1'b0;
            found.push_back(make_action(ars_pkg::ACT_ACK, addr));
         end else begin
            sess_waiting[addr] = 1'b1;
            sess_retries[addr] = '0;
            found.push_back(make_action(ars_pkg::ACT_SEND, addr));
         end
      end else if (kind == ars_pkg::REQ_SWEEP) begin
         for (int a = 0; a < ADDR_COUNT; a++) begin
            if (sess_present[a]) begin
               idle = now - sess_stamp[a];
               // A waiting session is retransmitted, or removed once out of retries.
               if (sess_waiting[a] && idle > ars_pkg::TIME_W'(cfg_retry_intv) &&
                   sess_retries[a] < cfg_retry_limit) begin
                  sess_retries[a] = sess_retries[a] + 1'b1;
                  sess_stamp[a]   = now;
                  found.push_back(make_action(ars_pkg::ACT_RETRY, ars_pkg::CADDR_W'(a)));
                  idle = '0;
               end else if (sess_waiting[a] && sess_retries[a] >= cfg_retry_limit) begin
                  drop_session(a);
                  found.push_back(make_action(ars_pkg::ACT_REMOVE, ars_pkg::CADDR_W'(a)));
               end
               // Any session idle past the timeout goes away.
               if (sess_present[a] && idle > cfg_timeout) begin
                  drop_session(a);
                  found.push_back(make_action(ars_pkg::ACT_REMOVE, ars_pkg::CADDR_W'(a)));
               end
            end
         end
      end
      if (found.size() != 0) begin
         found[found.size()-1].last_flag = 1'b1;
      end
      foreach (found[i]) begin
         expected_actions.push_back(found[i]);
      end
   endfunction

   // Compare each result transfer with the oldest expected action.
   always @(posedge clock) begin : check_actions
      action_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            report_mismatch("result with none expected, action", rsp_action, -1);
         end else begin
            want = expected_actions.pop_front();
            if (rsp_action !== want.action) begin
               report_mismatch("action", rsp_action, want.action);
            end
            if (rsp_target_addr !== want.target) begin
               report_mismatch("target_addr", rsp_target_addr, want.target);
            end
            if (rsp_last !== want.last_flag) begin
               report_mismatch("last", rsp_last, want.last_flag);
            end
         end
      end
   end

   // Result receiver: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_idle_on && $urandom_range(0, 99) < 21);
         end
      end
   end

   // Offer one request and wait for its transfer; the valid stays high afterward.
   task automatic send_item(input logic [ars_pkg::TYPE_W-1:0] kind,
                            input logic [ars_pkg::CADDR_W-1:0] addr,
                            input logic [ars_pkg::TIME_W-1:0] now);
      @(negedge clock);
      while (req_idle_on && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_client_addr <= addr;
      req_now_ms      <= now;
      do @(posedge clock); while (!req_ready);
      predict_table_actions(kind, addr, now);
   endtask

   // Stop offering and let the block finish all outstanding work.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ars_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ars_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr_write(idx, data);
   endtask

   // Write every register, plus the unused index, while the block is idle.
   task automatic set_config(input logic [ars_pkg::CSR_DATA_W-1:0] retries_word,
                             input logic [ars_pkg::CSR_DATA_W-1:0] intv_word,
                             input logic [ars_pkg::CSR_DATA_W-1:0] timeout_word);
      wait_idle();
      write_csr(CSR_UNUSED, $urandom);
      write_csr(ars_pkg::CSR_RETRY_LIMIT, retries_word);
      write_csr(ars_pkg::CSR_RETRY_INTV, intv_word);
      write_csr(ars_pkg::CSR_TIMEOUT, timeout_word);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ars_pkg::CADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 1) != 0) begin
         return ars_pkg::CADDR_W'($urandom_range(0, 3));
      end
      return ars_pkg::CADDR_W'($urandom_range(0, ADDR_COUNT - 1));
   endfunction

   // Advance the millisecond clock: small steps, interval and timeout edges, jumps.
   function automatic logic [ars_pkg::TIME_W-1:0] next_now();
      case ($urandom_range(0, 9))
         0:       now_track = $urandom;
         1:       now_track = now_track + cfg_timeout +
                              ars_pkg::TIME_W'($urandom_range(0, 1));
         2, 3:    now_track = now_track + ars_pkg::TIME_W'(cfg_retry_intv) +
                              ars_pkg::TIME_W'($urandom_range(0, 1));
         default: now_track = now_track +
                              ars_pkg::TIME_W'($urandom_range(0,
                                               int'(cfg_retry_intv) / 2 + 50));
      endcase
      return now_track;
   endfunction

   // Default configuration: interval and timeout edges, retry exhaustion, wrap of time.
   task automatic test_reset_defaults();
      logic [ars_pkg::TIME_W-1:0] base;
      base = 32'hFFFF_FE00;
      send_item(ars_pkg::REQ_RECV, 4'd0, base);
      send_item(ars_pkg::REQ_SEND, 4'd15, base);
      send_item(ars_pkg::REQ_SWEEP, 4'd9, base + 32'd1000);
      send_item(REQ_UNUSED, 4'd7, 32'hFFFF_FFFF);
      send_item(ars_pkg::REQ_SWEEP, 4'd0, base + 32'd1001);
      send_item(ars_pkg::REQ_RECV, 4'd15, base + 32'd1500);
      send_item(ars_pkg::REQ_SEND, 4'd15, base + 32'd1600);
      send_item(ars_pkg::REQ_SWEEP, 4'd3, base + 32'd2602);
      send_item(ars_pkg::REQ_SWEEP, 4'd12, base + 32'd3604);
      send_item(ars_pkg::REQ_SWEEP, 4'd5, base + 32'd4606);
      send_item(ars_pkg::REQ_SWEEP, 4'd10, base + 32'd4607);
      send_item(ars_pkg::REQ_SWEEP, 4'd15, base + 32'd10001);
   endtask

   // Register extremes, with masked upper data bits and time at both ends.
   task automatic test_config_limits();
      set_config(32'hFFFF_FF00, 32'hABCD_0000, 32'h0000_0000);
      send_item(ars_pkg::REQ_SEND, 4'd5, 32'hFFFF_FFFF);
      send_item(ars_pkg::REQ_RECV, 4'd6, 32'hFFFF_FFFF);
      send_item(ars_pkg::REQ_SWEEP, 4'd0, 32'hFFFF_FFFF);
      send_item(ars_pkg::REQ_SWEEP, 4'd0, 32'h0000_0000);
      set_config(32'h5A00_00FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ars_pkg::REQ_SEND, 4'd9, 32'h0000_0000);
      send_item(ars_pkg::REQ_SWEEP, 4'd4, 32'h0000_FFFF);
      send_item(ars_pkg::REQ_SWEEP, 4'd11, 32'h0001_0000);
      send_item(ars_pkg::REQ_SWEEP, 4'd14, 32'h8000_0000);
   endtask

   // Every slot in use: one sweep retransmits all, the next removes all.
   task automatic test_table_fill();
      logic [ars_pkg::CADDR_W-1:0] order [ADDR_COUNT];
      logic [ars_pkg::CADDR_W-1:0] swap;
      int j;
      set_config(($urandom & 32'hFFFF_FF00) | 32'd1, 32'd100, 32'd50000);
      for (int i = 0; i < ADDR_COUNT; i++) begin
         order[i] = ars_pkg::CADDR_W'(i);
      end
      for (int i = ADDR_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < ADDR_COUNT; i++) begin
         now_track = now_track + ars_pkg::TIME_W'($urandom_range(0, 20));
         send_item(ars_pkg::REQ_SEND, order[i], now_track);
      end
      now_track = now_track + ars_pkg::TIME_W'(101 + $urandom_range(0, 50));
      send_item(ars_pkg::REQ_SWEEP, pick_addr(), now_track);
      now_track = now_track + ars_pkg::TIME_W'($urandom_range(0, 300));
      send_item(ars_pkg::REQ_SWEEP, pick_addr(), now_track);
   endtask

   // Receiver holds off while requests keep coming, so the block stalls its input.
   task automatic test_output_backpressure();
      set_config(32'd3, 32'd500, 32'd5000);
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (14) begin
         send_item($urandom_range(0, 1) ? ars_pkg::REQ_SEND : ars_pkg::REQ_RECV,
                   pick_addr(), next_now());
      end
   endtask

   task automatic run_traffic(input int item_total);
      int sent;
      int pick;
      logic [ars_pkg::TYPE_W-1:0] kind;
      sent = 0;
      while (sent < item_total) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            kind = REQ_UNUSED;
         end else if (pick < 30) begin
            kind = ars_pkg::REQ_SWEEP;
         end else if (pick < 65) begin
            kind = ars_pkg::REQ_RECV;
         end else begin
            kind = ars_pkg::REQ_SEND;
         end
         send_item(kind, pick_addr(), next_now());
         if (kind != REQ_UNUSED) begin
            sent++;
         end
      end
   endtask

   // Mixed traffic under several random settings; the middle phase never idles.
   task automatic test_random_traffic();
      logic [ars_pkg::CSR_DATA_W-1:0] timeout_word;
      for (int phase = 0; phase < 3; phase++) begin
         timeout_word = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(500, 20000);
         set_config(($urandom & 32'hFFFF_FF00) | $urandom_range(0, 4),
                    ($urandom & 32'hFFFF_0000) | $urandom_range(0, 2000),
                    timeout_word);
         req_idle_on = (phase != 1);
         rsp_idle_on = (phase != 1);
         run_traffic(16);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = '0;
      req_client_addr = '0;
      req_now_ms      = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      error_count     = 0;
      rsp_hold_cycles = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      now_track       = 32'h0000_1000;
      reset_table_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_config_limits();
      test_table_fill();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
